[design/bpr_pkg.sv]
package bpr_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned MaxRepl    = 16;
  localparam int unsigned IdxW       = $clog2(MaxPattern);
  localparam int unsigned CntW       = $clog2(MaxPattern + 1);
  localparam int unsigned RepW       = $clog2(MaxRepl + 1);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  typedef logic [7:0] byte_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatLo  = 3'd0,
    CfgPatHi  = 3'd1,
    CfgPatLen = 3'd2,
    CfgRepLo  = 3'd3,
    CfgRepHi  = 3'd4,
    CfgRepLen = 3'd5
  } cfg_idx_e;

  // per-cell control from the top level
  typedef struct packed {
    logic shift;   // take the neighbor's byte this cycle
    logic active;  // cell lies inside the pattern window
  } cell_ctrl_t;

  // byte i of a 16-byte string packed into two 64-bit words
  function automatic byte_t word_byte(logic [63:0] lo, logic [63:0] hi, logic [3:0] i);
    byte_t b;
    if (i[3]) begin
      b = hi[8*i[2:0] +: 8];
    end else begin
      b = lo[8*i[2:0] +: 8];
    end
    return b;
  endfunction

endpackage

[design/bpr_in_if.sv]
interface bpr_in_if;
  logic         valid;
  logic         ready;
  logic [7:0]   data_byte;
  logic         end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

[design/bpr_out_if.sv]
interface bpr_out_if;
  logic         valid;
  logic         ready;
  logic [7:0]   out_byte;
  logic         has_byte;
  logic         last;

  modport source (output valid, output out_byte, output has_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input last, output ready);
endinterface

[design/bpr_cell.sv]
module bpr_cell (
  input  logic               clk_i,
  input  bpr_pkg::cell_ctrl_t ctrl_i,
  input  bpr_pkg::byte_t     byte_i,
  input  bpr_pkg::byte_t     pat_i,
  output bpr_pkg::byte_t     byte_o,
  output logic               hit_o
);
  import bpr_pkg::*;

  byte_t data_q, data_d;

  assign data_d = ctrl_i.shift ? byte_i : data_q;

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign byte_o = data_q;
  // compare the byte entering this cell against its aligned pattern byte
  assign hit_o  = !ctrl_i.active || (byte_i == pat_i);

endmodule

[design/byte_pattern_replace.sv]
// Output: the first result beat of a byte is loaded into the output register by the edge that
//   takes the byte; any further beats of the same burst follow one per cycle while the output is ready.
// Throughput: 1 byte per cycle while no burst is pending and the output is not stalled. A match
//   emits replacement_length beats and an end-of-packet flush emits the held bytes, one beat per
//   cycle while the output is ready; the input stalls while a burst drains.
// Reset: configuration registers clear to zero, no bytes held, output register empty.
module byte_pattern_replace (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bpr_in_if.sink                        in_ch,
  bpr_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [bpr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpr_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import bpr_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [63:0]     pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
  logic [4:0]      pat_len_q, rep_len_q;
  logic [CntW-1:0] len_eff;
  logic [RepW-1:0] rlen_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= '0;
      rep_lo_q  <= '0;
      rep_hi_q  <= '0;
      rep_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPatLo:  pat_lo_q  <= cfg_wdata_i;
        CfgPatHi:  pat_hi_q  <= cfg_wdata_i;
        CfgPatLen: pat_len_q <= cfg_wdata_i[4:0];
        CfgRepLo:  rep_lo_q  <= cfg_wdata_i;
        CfgRepHi:  rep_hi_q  <= cfg_wdata_i;
        CfgRepLen: rep_len_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // lengths above the string size saturate
  assign len_eff  = (pat_len_q > 5'(MaxPattern)) ? CntW'(MaxPattern) : CntW'(pat_len_q);
  assign rlen_eff = (rep_len_q > 5'(MaxRepl))    ? RepW'(MaxRepl)    : RepW'(rep_len_q);

  // ---------------------------------------------------------------------------
  // Handshake and sequencer state
  // ---------------------------------------------------------------------------
  logic            out_valid_q, out_valid_d;
  byte_t           out_byte_q, out_byte_d;
  logic            out_has_q, out_has_d;
  logic            out_last_q, out_last_d;

  logic [CntW-1:0] cnt_q, cnt_d;         // bytes held in the cell chain
  logic            flush_q, flush_d;     // packet ended, drain held bytes
  logic [RepW-1:0] rep_left_q, rep_left_d;
  logic [RepW-1:0] rep_idx_q, rep_idx_d;

  logic busy, out_free, acc, seq_go;

  // busy: a burst (replacement or flush) is still being sent beat by beat
  assign busy     = (rep_left_q != '0) || (flush_q && (cnt_q != '0));
  assign out_free = !out_valid_q || out_ch.ready;
  assign acc      = in_ch.valid && in_ch.ready;
  assign seq_go   = busy && out_free;

  assign in_ch.ready = !busy && out_free;

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 holds the newest byte, cell k the byte k places older.
  // Window win[k] is what enters cell k on a shift: win[0] is the incoming byte.
  // ---------------------------------------------------------------------------
  byte_t      win    [MaxPattern];
  byte_t      cell_q [MaxPattern];
  byte_t      pat_al [MaxPattern];
  logic [MaxPattern-1:0] hit;
  cell_ctrl_t cell_ctrl [MaxPattern];

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign win[k] = in_ch.data_byte;
    end else begin : g_body
      assign win[k] = cell_q[k-1];
    end

    // when the window is full, cell k sees pattern byte len-1-k
    assign pat_al[k] = word_byte(pat_lo_q, pat_hi_q,
                                 IdxW'(len_eff - CntW'(1) - CntW'(k)));

    assign cell_ctrl[k].shift  = acc;
    assign cell_ctrl[k].active = CntW'(k) < len_eff;

    bpr_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[k]),
      .byte_i (win[k]),
      .pat_i  (pat_al[k]),
      .byte_o (cell_q[k]),
      .hit_o  (hit[k])
    );
  end

  // ---------------------------------------------------------------------------
  // What one accepted byte causes
  // ---------------------------------------------------------------------------
  logic            len0, full, hit_full, miss, eop, from_flush;
  logic [CntW-1:0] cnt_inc, cnt_after, cnt_acc;
  logic [RepW-1:0] first_n, flush_n, rep_left_acc;
  logic [RepW:0]   total;
  byte_t           acc_byte;
  logic            acc_load, acc_has, acc_last;

  always_comb begin
    eop      = in_ch.end_of_packet;
    len0     = (len_eff == '0);
    cnt_inc  = cnt_q + CntW'(1);
    full     = !len0 && (cnt_inc >= len_eff);
    hit_full = full && (&hit);
    miss     = full && !(&hit);

    if (len0) begin
      // pass-through
      first_n   = RepW'(1);
      cnt_after = '0;
    end else if (hit_full) begin
      first_n   = rlen_eff;
      cnt_after = '0;
    end else if (miss) begin
      // oldest byte can no longer start a match
      first_n   = RepW'(1);
      cnt_after = len_eff - CntW'(1);
    end else begin
      first_n   = '0;
      cnt_after = cnt_inc;
    end

    flush_n    = eop ? RepW'(cnt_after) : '0;
    total      = (RepW+1)'(first_n) + (RepW+1)'(flush_n);
    from_flush = (first_n == '0) && (flush_n != '0);

    // first result goes straight to the output register
    if (len0) begin
      acc_byte = in_ch.data_byte;
    end else if (hit_full && (first_n != '0)) begin
      acc_byte = word_byte(rep_lo_q, rep_hi_q, 4'd0);
    end else if (miss) begin
      acc_byte = win[IdxW'(len_eff - CntW'(1))];
    end else if (from_flush) begin
      acc_byte = win[IdxW'(cnt_after - CntW'(1))];
    end else begin
      acc_byte = '0;  // bare end marker
    end

    acc_has      = (total != '0);
    acc_load     = acc_has || eop;
    acc_last     = eop && (total <= (RepW+1)'(1));
    rep_left_acc = (hit_full && (rlen_eff != '0)) ? rlen_eff - RepW'(1) : '0;
    cnt_acc      = from_flush ? cnt_after - CntW'(1) : cnt_after;
  end

  // ---------------------------------------------------------------------------
  // Burst sequencer: replacement bytes first, then held bytes oldest first
  // ---------------------------------------------------------------------------
  logic  rep_active;
  byte_t seq_byte;
  logic  seq_last;

  always_comb begin
    rep_active = (rep_left_q != '0);
    if (rep_active) begin
      seq_byte = word_byte(rep_lo_q, rep_hi_q, IdxW'(rep_idx_q));
      seq_last = flush_q && (rep_left_q == RepW'(1)) && (cnt_q == '0);
    end else begin
      seq_byte = cell_q[IdxW'(cnt_q - CntW'(1))];
      seq_last = (cnt_q == CntW'(1));
    end
  end

  // next state
  always_comb begin
    cnt_d      = cnt_q;
    flush_d    = flush_q;
    rep_left_d = rep_left_q;
    rep_idx_d  = rep_idx_q;

    if (acc) begin
      cnt_d      = cnt_acc;
      flush_d    = eop;
      rep_left_d = rep_left_acc;
      rep_idx_d  = RepW'(1);
    end else if (seq_go) begin
      if (rep_active) begin
        rep_left_d = rep_left_q - RepW'(1);
        rep_idx_d  = rep_idx_q + RepW'(1);
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end

    // new pattern length drops whatever is held
    if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CfgPatLen)) begin
      cnt_d = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    priority if (acc && acc_load) begin
      out_valid_d = 1'b1;
      out_byte_d  = acc_byte;
      out_has_d   = acc_has;
      out_last_d  = acc_last;
    end else if (seq_go) begin
      out_valid_d = 1'b1;
      out_byte_d  = seq_byte;
      out_has_d   = 1'b1;
      out_last_d  = seq_last;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      flush_q     <= 1'b0;
      rep_left_q  <= '0;
      rep_idx_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      flush_q     <= flush_d;
      rep_left_q  <= rep_left_d;
      rep_idx_q   <= rep_idx_d;
    end
  end

  // payload beat, no reset
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.out_byte = out_byte_q;
  assign out_ch.has_byte = out_has_q;
  assign out_ch.last     = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // between bursts, fewer bytes are held than the pattern is long
  a_held_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> ((cnt_q == '0) || (cnt_q < len_eff)))
    else $error("held byte count reached pattern length");

  // a last beat waiting in the output register means the packet is fully drained
  a_last_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> ((cnt_q == '0) && (rep_left_q == '0)))
    else $error("last beat sent with work still pending");

  // replacement index never runs past the replacement string
  a_rep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((RepW+1)'(rep_left_q) + (RepW+1)'(rep_idx_q)) <= (RepW+1)'(MaxRepl))
    else $error("replacement sequencer out of range");

  // a burst step always moves one beat into the output register
  a_burst_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_go |=> (out_valid_q && out_has_q))
    else $error("burst step produced no beat");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import bpr_pkg::*;

  // one output beat as the checker sees it
  typedef struct packed {
    byte_t data;
    logic  has_byte;
    logic  last;
  } out_beat_t;

  // Mirrors the block: holds its own copy of the registers and of the held-back
  // bytes, turns each accepted input beat into the output beats it must cause,
  // and checks the output stream against them in order.
  class rewrite_predictor;
    logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
    logic [4:0]  pat_len, rep_len;
    byte_t       held[16];
    int unsigned held_cnt;
    out_beat_t   step_beats[$];
    out_beat_t   expected_beats[$];
    int unsigned errors;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      rep_lo = '0;
      rep_hi = '0;
      pat_len = '0;
      rep_len = '0;
      foreach (held[i]) held[i] = '0;
      held_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] v);
      case (idx)
        CfgPatLo: pat_lo = v;
        CfgPatHi: pat_hi = v;
        CfgPatLen: begin
          pat_len = v[4:0];
          held_cnt = 0;  // a pattern length write drops what is held
        end
        CfgRepLo: rep_lo = v;
        CfgRepHi: rep_hi = v;
        CfgRepLen: rep_len = v[4:0];
        default: ;
      endcase
    endfunction

    function byte_t nth_byte(logic [63:0] lo, logic [63:0] hi, int unsigned i);
      logic [127:0] both;
      both = {hi, lo};
      return both[8*(i%16) +: 8];
    endfunction

    function void emit(byte_t d, logic has);
      if (step_beats.size() < 16) step_beats.push_back('{d, has, 1'b0});
    endfunction

    function void take_byte(byte_t b, logic eop);
      int unsigned len;
      int unsigned rlen;
      bit hit;
      step_beats.delete();
      len  = (pat_len > 5'd16) ? 16 : int'(pat_len);
      rlen = (rep_len > 5'd16) ? 16 : int'(rep_len);
      if (len == 0) begin
        for (int unsigned i = 0; i < held_cnt; i++) emit(held[i], 1'b1);
        held_cnt = 0;
        emit(b, 1'b1);
      end else begin
        if (held_cnt < 16) begin
          held[held_cnt] = b;
          held_cnt++;
        end
        // window full: either the whole pattern matches or the oldest byte goes
        if (held_cnt >= len) begin
          hit = 1'b1;
          for (int unsigned i = 0; i < len; i++)
            if (held[i] != nth_byte(pat_lo, pat_hi, i)) hit = 1'b0;
          if (hit) begin
            for (int unsigned i = 0; i < rlen; i++) emit(nth_byte(rep_lo, rep_hi, i), 1'b1);
            for (int unsigned i = 0; i + len < 16; i++) held[i] = held[i + len];
            held_cnt -= len;
          end else begin
            emit(held[0], 1'b1);
            for (int unsigned i = 0; i < 15; i++) held[i] = held[i + 1];
            held_cnt--;
          end
        end
        if (eop) begin
          for (int unsigned i = 0; i < held_cnt; i++) emit(held[i], 1'b1);
          held_cnt = 0;
        end
      end
      if (eop) begin
        // nothing left to carry the end: bare end marker
        if (step_beats.size() == 0) emit(8'h00, 1'b0);
        step_beats[step_beats.size() - 1].last = 1'b1;
        held_cnt = 0;
      end
      foreach (step_beats[k]) expected_beats.push_back(step_beats[k]);
    endfunction

    function void check_beat(byte_t d, logic has, logic lst);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected: got byte %02h has %b last %b",
                 $time, d, has, lst);
      end else begin
        want = expected_beats.pop_front();
        if (want.data !== d || want.has_byte !== has || want.last !== lst) begin
          errors++;
          $display({"%0t: beat mismatch: expected byte %02h has %b last %b, ",
                    "got byte %02h has %b last %b"},
                   $time, want.data, want.has_byte, want.last, d, has, lst);
        end
      end
    endfunction

    function void check_drained();
      if (expected_beats.size() != 0) begin
        errors++;
        $display("%0t: %0d expected beats never arrived, next: byte %02h has %b last %b",
                 $time, expected_beats.size(), expected_beats[0].data,
                 expected_beats[0].has_byte, expected_beats[0].last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  bpr_in_if  in_ch ();
  bpr_out_if out_ch ();

  byte_pattern_replace uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  rewrite_predictor pred = new();

  // idling controls: calm sides never idle
  bit          src_calm;
  bit          snk_calm;
  int unsigned stall_left;
  int unsigned sent_items;

  // current phase: pattern bytes, effective length, byte alphabet
  byte_t       cur_pat[16];
  int unsigned eff_len;
  byte_t       alpha[3];

  always begin
    #6ns clk_i = 1'b1;
    #6ns clk_i = 1'b0;
  end

  // Output side: results are checked at the edge where they are taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      pred.check_beat(out_ch.out_byte, out_ch.has_byte, out_ch.last);
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Sink ready: low in reset, then high by default, random stalls unless the sink is calm.
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!snk_calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // Entered just after a rising edge (or at start); leaves at the edge that
  // takes the beat, with valid still high so back-to-back beats need no toggle.
  task automatic send_byte(byte_t b, logic eop);
    int unsigned gap;
    gap = src_calm ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_packet <= eop;
    do @(posedge clk_i); while (!in_ch.ready);
    pred.take_byte(b, eop);
    sent_items++;
  endtask

  task automatic send_pkt(byte_t bytes[$]);
    foreach (bytes[k]) send_byte(bytes[k], logic'(k == bytes.size() - 1));
  endtask

  // Drop valid, wait until every expected beat is out, then let the block
  // finish any byte that produced nothing. Bounded so a lost beat cannot hang.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pred.expected_beats.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
  endtask

  // Only called while idle; the predictor takes the write at once.
  task automatic set_reg(cfg_idx_e idx, logic [63:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    pred.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // pattern length mix: off, short, mid, full and oversized
  function automatic logic [4:0] draw_pat_len();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd2;
      3: return 5'd3;
      4, 5: return 5'($urandom_range(2, 8));
      6: return 5'($urandom_range(9, 15));
      7: return 5'd16;
      8: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic set_pat_len(logic [4:0] plen);
    eff_len = (plen > 5'd16) ? 16 : int'(plen);
    set_reg(CfgPatLen, {59'd0, plen});
  endtask

  // Fresh phase: pattern drawn from a tiny alphabet so partial and
  // overlapping matches show up often.
  task automatic new_setting();
    logic [127:0] pat_bits;
    logic [127:0] rep_bits;
    logic [4:0]   rlen;
    int unsigned  r;
    foreach (alpha[i]) alpha[i] = byte_t'($urandom_range(0, 255));
    r = $urandom_range(0, 3);
    if (r == 0) alpha[0] = 8'h00;
    if (r == 1) alpha[1] = 8'hFF;
    for (int i = 0; i < 16; i++) begin
      cur_pat[i] = ($urandom_range(0, 3) == 0) ? alpha[2] : alpha[$urandom_range(0, 1)];
      pat_bits[8*i +: 8] = cur_pat[i];
    end
    rep_bits = {$urandom, $urandom, $urandom, $urandom};
    r = $urandom_range(0, 7);
    if (r == 0) rep_bits = '1;
    if (r == 1) rep_bits = '0;
    case ($urandom_range(0, 7))
      0: rlen = 5'd0;
      1: rlen = 5'd1;
      2: rlen = 5'd16;
      3: rlen = 5'($urandom_range(17, 31));
      default: rlen = 5'($urandom_range(0, 6));
    endcase
    set_reg(CfgPatLo, pat_bits[63:0]);
    set_reg(CfgPatHi, pat_bits[127:64]);
    set_reg(CfgRepLo, rep_bits[63:0]);
    set_reg(CfgRepHi, rep_bits[127:64]);
    set_reg(CfgRepLen, {59'd0, rlen});
    set_pat_len(draw_pat_len());
  endtask

  // Mostly whole pattern copies in random filler, some cut-off prefixes and
  // noise; now and then the packet stops halfway for a register write.
  task automatic send_random_packet();
    byte_t       pkt[$];
    int unsigned plen;
    int unsigned cut;
    int unsigned r;
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
    while (pkt.size() < plen) begin
      r = $urandom_range(0, 99);
      if (r < 40 && eff_len > 0) begin
        for (int unsigned i = 0; i < eff_len; i++) pkt.push_back(cur_pat[i]);
      end else if (r < 55 && eff_len > 1) begin
        for (int unsigned i = 0; i < $urandom_range(1, eff_len - 1); i++)
          pkt.push_back(cur_pat[i]);
      end else if (r < 85) begin
        pkt.push_back(alpha[$urandom_range(0, 2)]);
      end else begin
        pkt.push_back(byte_t'($urandom_range(0, 255)));
      end
    end
    cut = (pkt.size() > 1 && $urandom_range(0, 14) == 0) ? $urandom_range(1, pkt.size() - 1) : 0;
    foreach (pkt[k]) begin
      if (cut != 0 && k == cut) begin
        settle();
        if ($urandom_range(0, 1) == 0) set_pat_len(draw_pat_len());
        else set_reg(CfgRepLo, {$urandom, $urandom});
      end
      send_byte(pkt[k], logic'(k == pkt.size() - 1));
    end
  endtask

  initial begin
    int unsigned rnd_start;
    byte_t       pkt[$];
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_packet = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_wdata_i         = '0;
    src_calm            = 1'b0;
    snk_calm            = 1'b0;
    sent_items          = 0;
    eff_len             = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers still at reset: pattern off, bytes pass straight through
    pkt = {8'h00, 8'hFF};
    send_pkt(pkt);
    settle();

    // two-byte pattern "AB" -> "XYZ"; a false start on A, a hit, a trailing A
    set_reg(CfgPatLo, 64'h4241);
    set_reg(CfgPatLen, 64'd2);
    set_reg(CfgRepLo, 64'h5A5958);
    set_reg(CfgRepLen, 64'd3);
    pkt = {8'h41, 8'h41, 8'h42, 8'h43, 8'h41};
    send_pkt(pkt);
    settle();

    // length written mid-packet: the held A is dropped, then A alone matches
    send_byte(8'h41, 1'b0);
    settle();
    set_reg(CfgPatLen, 64'd1);
    send_byte(8'h41, 1'b1);
    settle();

    // empty replacement on the end byte: only a bare end marker goes out
    set_reg(CfgRepLen, 64'd0);
    send_byte(8'h41, 1'b1);
    settle();

    // pattern byte rewritten mid-packet: B passes, then B matches
    set_reg(CfgRepLen, 64'd3);
    send_byte(8'h42, 1'b0);
    settle();
    set_reg(CfgPatLo, 64'h42);
    send_byte(8'h42, 1'b1);
    settle();

    // oversized replacement length: clipped to 16 bytes, zeros then all-ones
    set_reg(CfgRepLo, 64'h0);
    set_reg(CfgRepHi, 64'hFFFF_FFFF_FFFF_FFFF);
    set_reg(CfgRepLen, 64'd31);
    send_byte(8'h42, 1'b1);
    settle();

    // oversized pattern length acts as 16: a short packet is held then flushed
    set_reg(CfgPatHi, 64'hFFFF_FFFF_FFFF_FFFF);
    set_reg(CfgPatLen, 64'd31);
    pkt = {8'h42, 8'h00, 8'hFF};
    send_pkt(pkt);

    // random phases; each settle is a full pause of the sender
    rnd_start = sent_items;
    while (sent_items - rnd_start < 320) begin
      settle();
      new_setting();
      src_calm = ($urandom_range(0, 3) == 0);
      snk_calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 6)) send_random_packet();
    end

    settle();
    pred.check_drained();
    if (pred.errors == 0) begin
      $display("PASS byte_pattern_replace");
    end else begin
      $display("FAIL byte_pattern_replace");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #20ms;
    $display("FAIL byte_pattern_replace");
    $finish;
  end

endmodule

[filelist.f]
design/bpr_pkg.sv
design/bpr_in_if.sv
design/bpr_out_if.sv
design/bpr_cell.sv
design/byte_pattern_replace.sv
tb/tb_top.sv
